// ===== rtl/htkv_pkg.sv =====
package htkv_pkg;

    localparam int KEY_W = 31;
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;

    localparam int NUM_BUCKETS_DEF = 1024;
    localparam int WAYS_DEF        = 4;

    // stream widths: input tdata holds key then value, result holds hit, value, full
    localparam int IN_W         = KEY_W + VAL_W;
    localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W        = 1 + VAL_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // packed so that hit lands in the lowest bit
    typedef struct packed {
        logic              bucket_full;
        logic [VAL_W-1:0]  found_value;
        logic              hit;
    } result_t;

endpackage

// ===== rtl/htkv_bucket.sv =====
module htkv_bucket
    import htkv_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int BW          = $clog2(NUM_BUCKETS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [BW-1:0]    bucket
);

    localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            logic          done_reg;
            logic [BW-1:0] bucket_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    bucket_reg <= key[BW-1:0];
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end else begin : g_recip
            // quotient by rounded-up reciprocal, exact for every key below 2^KEY_W
            localparam int               SHIFT     = KEY_W + BW;
            localparam int               PROD_W    = KEY_W + 32;
            localparam logic [63:0]      ONE_SHIFT = 64'd1 << SHIFT;
            localparam logic [63:0]      NB_WIDE   = 64'(NUM_BUCKETS);
            localparam logic [63:0]      RECIP_W   = (ONE_SHIFT + NB_WIDE - 64'd1) / NB_WIDE;
            localparam logic [31:0]      RECIP     = RECIP_W[31:0];
            localparam logic [KEY_W-1:0] NB        = KEY_W'(NUM_BUCKETS);

            logic              quo_valid_reg;
            logic              done_reg;
            logic [KEY_W-1:0]  key_reg;
            logic [KEY_W-1:0]  quo_reg;
            logic [BW-1:0]     rem_reg;
            logic [PROD_W-1:0] prod;

            assign prod = PROD_W'(key) * PROD_W'(RECIP);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    quo_valid_reg <= 1'b0;
                    done_reg      <= 1'b0;
                end else begin
                    quo_valid_reg <= start;
                    done_reg      <= quo_valid_reg;
                end
                if (start) begin
                    key_reg <= key;
                    quo_reg <= KEY_W'(prod >> SHIFT);
                end
                // remainder from the registered quotient once it is valid
                if (quo_valid_reg) begin
                    rem_reg <= BW'(key_reg - quo_reg * NB);
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
    endgenerate

endmodule

// ===== rtl/htkv_row_ram.sv =====
module htkv_row_ram #(
    parameter int ROWS  = 1024,
    parameter int ROW_W = 256,
    parameter int AW    = $clog2(ROWS)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [ROW_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [ROW_W-1:0] rdata
);

    logic [ROW_W-1:0] mem [ROWS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/htkv_way_logic.sv =====
module htkv_way_logic
    import htkv_pkg::*;
#(
    parameter int WAYS  = WAYS_DEF,
    parameter int ROW_W = WAYS * (1 + KEY_W + VAL_W)
) (
    input  op_t              op,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    input  logic [ROW_W-1:0] row_in,
    output logic [ROW_W-1:0] row_out,
    output logic             wr_en,
    output result_t          res
);

    // row layout from the top: valid bits, keys, values; way 0 lowest in each
    localparam int KEY_BASE = WAYS * VAL_W;

    logic [WAYS-1:0]  valid;
    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  free;
    logic [WAYS-1:0]  match_oh;
    logic [WAYS-1:0]  free_oh;
    logic [WAYS-1:0]  valid_new;
    logic             any_match;
    logic             any_free;
    logic [VAL_W-1:0] hit_value;
    logic             do_insert;
    logic             do_remove;

    assign valid = row_in[ROW_W-1 -: WAYS];

    always_comb begin
        match     = '0;
        hit_value = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = valid[w] && (row_in[KEY_BASE + w*KEY_W +: KEY_W] == key);
        end
        free     = ~valid;
        // lowest set bit only
        match_oh = match & (~match + WAYS'(1));
        free_oh  = free & (~free + WAYS'(1));
        for (int w = 0; w < WAYS; w++) begin
            if (match_oh[w]) begin
                hit_value = hit_value | row_in[w*VAL_W +: VAL_W];
            end
        end
    end

    assign any_match = |match;
    assign any_free  = |free;
    assign do_insert = (op == OP_INSERT) && any_free;
    assign do_remove = (op == OP_REMOVE) && any_match;
    assign wr_en     = do_insert || do_remove;

    always_comb begin
        valid_new = valid;
        if (do_insert) begin
            valid_new = valid | free_oh;
        end else if (do_remove) begin
            valid_new = valid & ~match_oh;
        end
        row_out = row_in;
        for (int w = 0; w < WAYS; w++) begin
            if (free_oh[w]) begin
                row_out[KEY_BASE + w*KEY_W +: KEY_W] = key;
                row_out[w*VAL_W +: VAL_W]            = value;
            end
        end
        row_out[ROW_W-1 -: WAYS] = valid_new;
    end

    always_comb begin
        res = '0;
        case (op)
            OP_INSERT: begin
                res.hit         = any_free;
                res.bucket_full = !any_free;
            end
            OP_REMOVE: begin
                res.hit = any_match;
            end
            OP_SEARCH: begin
                res.hit         = any_match;
                res.found_value = any_match ? hit_value : MISS_VALUE;
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule

// ===== rtl/hash_table_key_value_store.sv =====
// Key-value table with NUM_BUCKETS buckets of WAYS entries each; the bucket of a key is the
// key modulo NUM_BUCKETS. Each bucket is one row of a single-port-write, registered-read
// memory holding every way's valid bit, key and value, so an item costs one row read and
// at most one row write. s_axis_tuser carries the operation (insert, remove, search, or
// no-op), s_axis_tdata the key and value. Insert takes the lowest free way or reports
// bucket_full, remove clears the lowest matching way, search returns the value of the
// lowest matching way or -1 on a miss. One item is processed at a time: accept, bucket
// select, row read, resolve and write back. With a non-power-of-two bucket count the bucket
// comes from a reciprocal multiplication followed by a registered multiply-subtract. A
// finished result sits in an output register, so the next item is accepted while it waits;
// that item then holds in resolve until the register drains. After reset a clearing pass
// writes every row, during which no item is accepted.
module hash_table_key_value_store
    import htkv_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int WAYS        = WAYS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key[30:0], value[62:31]
    input  logic [OP_W-1:0]        s_axis_tuser,   // op[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // hit[0], found_value[32:1], bucket_full[33]
);

    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int ROW_W = WAYS * (1 + KEY_W + VAL_W);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_RESOLVE
    } state_t;

    state_t           state_reg;
    logic [BW-1:0]    clr_reg;
    logic [BW-1:0]    row_reg;
    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             m_valid_reg;
    result_t          m_data_reg;

    logic             accept;
    logic             out_free;
    logic             hash_done;
    logic [BW-1:0]    hash_bucket;
    logic             ram_we;
    logic [BW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] row_new;
    logic             row_wr;
    result_t          res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, m_data_reg};

    htkv_bucket #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BW          (BW)
    ) u_bucket (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (s_axis_tdata[KEY_W-1:0]),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    htkv_row_ram #(
        .ROWS  (NUM_BUCKETS),
        .ROW_W (ROW_W),
        .AW    (BW)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (row_reg),
        .rdata (ram_rdata)
    );

    htkv_way_logic #(
        .WAYS  (WAYS),
        .ROW_W (ROW_W)
    ) u_way_logic (
        .op      (op_reg),
        .key     (key_reg),
        .value   (value_reg),
        .row_in  (ram_rdata),
        .row_out (row_new),
        .wr_en   (row_wr),
        .res     (res)
    );

    // clearing pass owns the write port until the table is empty
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = (state_reg == ST_RESOLVE) && out_free && row_wr;
            ram_waddr = row_reg;
            ram_wdata = row_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // resolve reloads the output register itself
            if (m_valid_reg && m_axis_tready && state_reg != ST_RESOLVE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == BW'(NUM_BUCKETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg    <= op_t'(s_axis_tuser);
                        key_reg   <= s_axis_tdata[KEY_W-1:0];
                        value_reg <= s_axis_tdata[KEY_W +: VAL_W];
                        state_reg <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (hash_done) begin
                        row_reg   <= hash_bucket;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_RESOLVE;
                end
                ST_RESOLVE: begin
                    // row data stays put while the result waits: the read address is unchanged
                    if (out_free) begin
                        m_data_reg  <= res;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
